/* design/nscc_pkg.sv */
package nscc_pkg;

    localparam int unsigned MAX_LEN_DEF = 120;
    localparam int unsigned LEN_W       = 7;
    localparam int unsigned XOR_W       = 9;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_F       = 8'h46;

    localparam logic [LEN_W-1:0] MIN_OK_LEN = 7'd5;

    typedef logic [XOR_W-1:0] t_xor;

    function automatic t_xor sext9(input logic [7:0] b);
        return {b[7], b};
    endfunction

    // Uppercase hex digit value; anything else reads as zero.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
        end else if (c >= CH_A && c <= CH_F) begin
            d = c - CH_A + 8'd10;
        end
        return d[3:0];
    endfunction

endpackage

/* design/nmea_sentence_checksum_checker_unit.sv */
// NMEA sentence checksum checker.
//
// Input channel (i_rx_valid / o_rx_ready / i_rx_byte): one received
// character per request, straight from a UART receiver. A '$' restarts the
// line, a newline closes it and then starts the next line, every other byte
// is appended.
//
// Result channel (o_res_valid / i_res_ready): one result per newline with
// o_checksum_ok, o_has_gga, o_has_rmc and o_line_length.
//
// Throughput: one byte per cycle. The line state (running XOR, last four
// characters, count, flags) updates in the cycle a byte is accepted.
// Latency: a result is valid the cycle after its newline is accepted.
//
// Stalls: the result sits in a single output register. A new byte is taken
// while that register is empty or being drained in the same cycle; while
// a result waits and i_res_ready is low, o_rx_ready drops.
//
// Reset (i_rst_n low, synchronous): line state clears to an empty line, no
// result is pending; a newline right after reset yields an all-zero result.
module nmea_sentence_checksum_checker_unit
    import nscc_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rx_valid,
    output logic             o_rx_ready,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic             o_checksum_ok,
    output logic             o_has_gga,
    output logic             o_has_rmc,
    output logic [LEN_W-1:0] o_line_length
);

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_LEN);

    // line state
    t_xor             r_xor,      n_xor;
    logic [7:0]       r_recent [4];
    logic [7:0]       n_recent [4];
    logic [LEN_W-1:0] r_count,    n_count;
    logic             r_too_long, n_too_long;
    logic             r_gga,      n_gga;
    logic             r_rmc,      n_rmc;

    // result register
    logic             r_res_valid;
    logic             r_ok;
    logic             r_res_gga;
    logic             r_res_rmc;
    logic [LEN_W-1:0] r_res_len;

    logic rx_take;
    logic is_nl;
    logic is_dollar;
    logic line_ok;
    t_xor body;
    t_xor given;

    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign rx_take    = i_rx_valid && o_rx_ready;
    assign is_nl      = (i_rx_byte == CH_NEWLINE);
    assign is_dollar  = (i_rx_byte == CH_DOLLAR);

    // Checksum test on the line as it stands when the newline shows up.
    always_comb begin
        body  = r_xor ^ sext9(r_recent[3]) ^ sext9(r_recent[2])
                      ^ sext9(r_recent[1]) ^ sext9(r_recent[0]);
        given = {1'b0, hex_val(r_recent[2]), hex_val(r_recent[1])};
        line_ok = !r_too_long && (r_count >= MIN_OK_LEN)
                  && (r_recent[3] == CH_STAR) && ((body ^ given) == '0);
    end

    // Next line state.
    always_comb begin
        n_xor      = r_xor;
        n_recent   = r_recent;
        n_count    = r_count;
        n_too_long = r_too_long;
        n_gga      = r_gga;
        n_rmc      = r_rmc;
        if (is_nl || is_dollar) begin
            // restart: the byte becomes the first stored character
            n_xor       = '0;
            n_recent[0] = i_rx_byte;
            n_recent[1] = '0;
            n_recent[2] = '0;
            n_recent[3] = '0;
            n_count     = LEN_W'(1);
            n_too_long  = 1'b0;
            n_gga       = 1'b0;
            n_rmc       = 1'b0;
        end else begin
            if (r_count != '0) begin
                n_xor = r_xor ^ sext9(i_rx_byte);
            end
            if (r_count >= MaxLen) begin
                n_too_long = 1'b1;
            end else begin
                n_count = r_count + LEN_W'(1);
            end
            n_recent[3] = r_recent[2];
            n_recent[2] = r_recent[1];
            n_recent[1] = r_recent[0];
            n_recent[0] = i_rx_byte;
            if (r_recent[1] == CH_G && r_recent[0] == CH_G && i_rx_byte == CH_A) begin
                n_gga = 1'b1;
            end
            if (r_recent[1] == CH_R && r_recent[0] == CH_M && i_rx_byte == CH_C) begin
                n_rmc = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor      <= '0;
            r_recent   <= '{default: '0};
            r_count    <= '0;
            r_too_long <= 1'b0;
            r_gga      <= 1'b0;
            r_rmc      <= 1'b0;
        end else if (rx_take) begin
            r_xor      <= n_xor;
            r_recent   <= n_recent;
            r_count    <= n_count;
            r_too_long <= n_too_long;
            r_gga      <= n_gga;
            r_rmc      <= n_rmc;
        end
    end

    // Result register: loaded on an accepted newline, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (rx_take && is_nl) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take && is_nl) begin
            r_ok      <= line_ok;
            r_res_gga <= r_gga;
            r_res_rmc <= r_rmc;
            r_res_len <= r_count;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_checksum_ok = r_ok;
    assign o_has_gga     = r_res_gga;
    assign o_has_rmc     = r_res_rmc;
    assign o_line_length = r_res_len;

    // A result only appears after a newline was taken.
    a_res_from_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> $past(rx_take && is_nl))
        else $error("result without newline");

    // Count never passes the line limit.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MaxLen)
        else $error("char count over limit");

    // A stalled result blocks new bytes.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_res_ready) |-> !o_rx_ready)
        else $error("byte taken over a stalled result");

    // A passing line has the minimum length.
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_ok) |-> (r_res_len >= MIN_OK_LEN))
        else $error("pass on short line");

endmodule
